@@ hdl/amdu_pkg.sv @@
// ----------------------------------------------------------------------------
// amdu_pkg
// Shared types and constants of the accumulator multiply/divide unit.
// ----------------------------------------------------------------------------
package amdu_pkg;

  localparam int WORD_W = 16;
  localparam int OP_W   = 4;
  localparam int CNT_W  = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_DIV8     = 4'd0,
    OP_IMUL8    = 4'd1,
    OP_IMUL16   = 4'd2,
    OP_IMUL_BX  = 4'd3,
    OP_IMUL_DX  = 4'd4,
    OP_MUL16    = 4'd5,
    OP_SWAP_AXDX = 4'd6,
    OP_SWAP_BXAX = 4'd7,
    OP_AAM      = 4'd8,
    OP_LOAD_AX  = 4'd9,
    OP_LOAD_BX  = 4'd10,
    OP_LOAD_DX  = 4'd11
  } op_t;

endpackage

@@ hdl/amdu_req_if.sv @@
// ----------------------------------------------------------------------------
// amdu_req_if
// Operation channel: one beat carries an op code and a 16-bit operand.
// ----------------------------------------------------------------------------
interface amdu_req_if;
  logic                      valid;
  logic                      ready;
  logic [amdu_pkg::OP_W-1:0] op;
  amdu_pkg::word_t           operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink   (input valid, input op, input operand, output ready);
endinterface

@@ hdl/amdu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// amdu_rsp_if
// Result channel: one beat carries AX, BX, DX, carry and divide error.
// ----------------------------------------------------------------------------
interface amdu_rsp_if;
  logic            valid;
  logic            ready;
  amdu_pkg::word_t ax_out;
  amdu_pkg::word_t bx_out;
  amdu_pkg::word_t dx_out;
  logic            carry_out;
  logic            divide_error;

  modport source (output valid, output ax_out, output bx_out, output dx_out,
                  output carry_out, output divide_error, input ready);
  modport sink   (input valid, input ax_out, input bx_out, input dx_out,
                  input carry_out, input divide_error, output ready);
endinterface

@@ hdl/accumulator_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// accumulator_mul_div_unit
// AX/BX/DX register file with multiply, divide, AAM, swap and load ops.
// Multiply/divide: operand set-up at the accept, 16 steps of the shared
// 18-bit add/subtract unit, one write-back, then the result beat is valid.
// Loads, swaps, unused codes and zero divisors: result valid next cycle.
// One op at a time: a new op is accepted only once the result beat is taken.
// Sync reset clears AX, BX, DX, carry, sequencer.
// ----------------------------------------------------------------------------
module accumulator_mul_div_unit (
  input  logic       clk,
  input  logic       rst,
  amdu_req_if.sink   req,
  amdu_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t                      state;
  amdu_pkg::word_t             ax, bx, dx;
  logic                        carry;
  logic                        derr;
  amdu_pkg::op_t               op_q;
  amdu_pkg::word_t             hi, lo, opb;
  logic                        neg;
  logic [amdu_pkg::CNT_W-1:0]  cnt;

  amdu_pkg::op_t   op_in;
  amdu_pkg::word_t mul_a, mul_b, a_mag, b_mag;
  logic            mul_sgn, a_neg, b_neg;
  logic            is_div;
  logic [17:0]     add_a, add_b, add_s;
  logic            add_ci;
  logic [31:0]     prod, res;

  assign op_in = amdu_pkg::op_t'(req.op);

  // operand set-up for multiplies
  always_comb begin
    mul_a   = ax;
    mul_b   = req.operand;
    mul_sgn = 1'b1;
    case (op_in)
      amdu_pkg::OP_IMUL8: begin
        mul_a = {{8{ax[7]}}, ax[7:0]};
        mul_b = {{8{req.operand[7]}}, req.operand[7:0]};
      end
      amdu_pkg::OP_IMUL_BX: mul_a = bx;
      amdu_pkg::OP_IMUL_DX: mul_a = dx;
      amdu_pkg::OP_MUL16:   mul_sgn = 1'b0;
      default: ;
    endcase
    a_neg = mul_sgn & mul_a[15];
    b_neg = mul_sgn & mul_b[15];
    a_mag = a_neg ? (~mul_a + 16'd1) : mul_a;
    b_mag = b_neg ? (~mul_b + 16'd1) : mul_b;
  end

  // shared add/subtract unit
  assign is_div = (op_q == amdu_pkg::OP_DIV8) || (op_q == amdu_pkg::OP_AAM);

  always_comb begin
    if (is_div) begin
      add_a  = {1'b0, hi, lo[15]};
      add_b  = ~{2'b00, opb};
      add_ci = 1'b1;
    end else begin
      add_a  = {2'b00, hi};
      add_b  = lo[0] ? {2'b00, opb} : 18'd0;
      add_ci = 1'b0;
    end
    add_s = add_a + add_b + {17'd0, add_ci};
  end

  assign prod = {hi, lo};
  assign res  = neg ? (~prod + 32'd1) : prod;

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = (state == ST_RESP);
  assign rsp.ax_out       = ax;
  assign rsp.bx_out       = bx;
  assign rsp.dx_out       = dx;
  assign rsp.carry_out    = carry;
  assign rsp.divide_error = derr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ax    <= '0;
      bx    <= '0;
      dx    <= '0;
      carry <= 1'b0;
      derr  <= 1'b0;
      op_q  <= amdu_pkg::OP_LOAD_AX;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_q  <= op_in;
            derr  <= 1'b0;
            cnt   <= '1;
            hi    <= '0;
            state <= ST_RESP;
            case (op_in)
              amdu_pkg::OP_DIV8: begin
                opb <= {8'd0, req.operand[7:0]};
                lo  <= ax;
                if (req.operand[7:0] == 8'd0) begin
                  derr <= 1'b1;
                end else begin
                  state <= ST_RUN;
                end
              end
              amdu_pkg::OP_AAM: begin
                opb <= req.operand;
                lo  <= {8'd0, ax[7:0]};
                if (req.operand == '0) begin
                  derr <= 1'b1;
                end else begin
                  state <= ST_RUN;
                end
              end
              amdu_pkg::OP_IMUL8, amdu_pkg::OP_IMUL16, amdu_pkg::OP_IMUL_BX,
              amdu_pkg::OP_IMUL_DX, amdu_pkg::OP_MUL16: begin
                opb   <= a_mag;
                lo    <= b_mag;
                neg   <= a_neg ^ b_neg;
                state <= ST_RUN;
              end
              amdu_pkg::OP_SWAP_AXDX: begin
                ax <= dx;
                dx <= ax;
              end
              amdu_pkg::OP_SWAP_BXAX: begin
                ax <= bx;
                bx <= ax;
              end
              amdu_pkg::OP_LOAD_AX: ax <= req.operand;
              amdu_pkg::OP_LOAD_BX: bx <= req.operand;
              amdu_pkg::OP_LOAD_DX: dx <= req.operand;
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (is_div) begin
            if (!add_s[17]) begin
              hi <= add_s[15:0];
              lo <= {lo[14:0], 1'b1};
            end else begin
              hi <= {hi[14:0], lo[15]};
              lo <= {lo[14:0], 1'b0};
            end
          end else begin
            hi <= add_s[16:1];
            lo <= {add_s[0], lo[15:1]};
          end
          if (cnt == '0) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_RESP;
          case (op_q)
            amdu_pkg::OP_DIV8: ax <= {hi[7:0], lo[7:0]};
            amdu_pkg::OP_AAM:  ax <= {lo[7:0], hi[7:0]};
            amdu_pkg::OP_IMUL8: ax <= res[15:0];
            amdu_pkg::OP_IMUL16, amdu_pkg::OP_MUL16: begin
              ax <= res[15:0];
              dx <= res[31:16];
            end
            amdu_pkg::OP_IMUL_BX: begin
              bx    <= res[15:0];
              carry <= (res[31:16] == 16'd0);
            end
            amdu_pkg::OP_IMUL_DX: begin
              dx    <= res[15:0];
              carry <= (res[31:16] == 16'd0);
            end
            default: ;
          endcase
        end
        ST_RESP: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ bench/amdu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdu_checker
// Watches the operation and result channels of the multiply/divide unit.
// Keeps its own copy of AX, BX, DX and carry, works out the expected result
// of every accepted operation and compares each result beat with the oldest
// expected one. Hands the failure count and the backlog to the bench top.
// ----------------------------------------------------------------------------
module amdu_checker (
  input  logic clk,
  input  logic rst,
  amdu_req_if  req,
  amdu_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    amdu_pkg::word_t ax;
    amdu_pkg::word_t bx;
    amdu_pkg::word_t dx;
    logic            carry;
    logic            derr;
  } regs_rsp_t;

  amdu_pkg::word_t ax_q, bx_q, dx_q;
  logic            cf_q;
  regs_rsp_t       want_q[$];
  int              err_cnt = 0;
  int              depth   = 0;

  assign errors  = err_cnt;
  assign pending = depth;

  // Executes one operation on the shadow registers and queues the outcome.
  task automatic exec_op(input logic [amdu_pkg::OP_W-1:0] code,
                         input amdu_pkg::word_t value);
    amdu_pkg::word_t    ax, bx, dx, quo, rem;
    logic               cf, derr;
    logic signed [15:0] prod8;
    logic signed [31:0] prod;
    logic        [31:0] uprod;
    regs_rsp_t          res;
    ax   = ax_q;
    bx   = bx_q;
    dx   = dx_q;
    cf   = cf_q;
    derr = 1'b0;
    case (code)
      amdu_pkg::OP_DIV8: begin
        if (value[7:0] == 8'h00) begin
          derr = 1'b1;
        end else begin
          quo = ax / value[7:0];
          rem = ax % value[7:0];
          ax  = {rem[7:0], quo[7:0]};
        end
      end
      amdu_pkg::OP_IMUL8: begin
        prod8 = $signed(ax[7:0]) * $signed(value[7:0]);
        ax    = prod8;
      end
      amdu_pkg::OP_IMUL16: begin
        prod     = $signed(ax) * $signed(value);
        {dx, ax} = prod;
      end
      amdu_pkg::OP_IMUL_BX: begin
        prod = $signed(bx) * $signed(value);
        bx   = prod[15:0];
        cf   = (prod[31:16] == 16'h0000);
      end
      amdu_pkg::OP_IMUL_DX: begin
        prod = $signed(dx) * $signed(value);
        dx   = prod[15:0];
        cf   = (prod[31:16] == 16'h0000);
      end
      amdu_pkg::OP_MUL16: begin
        uprod    = ax * value;
        {dx, ax} = uprod;
      end
      amdu_pkg::OP_SWAP_AXDX: begin
        ax = dx_q;
        dx = ax_q;
      end
      amdu_pkg::OP_SWAP_BXAX: begin
        ax = bx_q;
        bx = ax_q;
      end
      amdu_pkg::OP_AAM: begin
        if (value == 16'h0000) begin
          derr = 1'b1;
        end else begin
          quo = {8'h00, ax[7:0]} / value;
          rem = {8'h00, ax[7:0]} % value;
          ax  = {quo[7:0], rem[7:0]};
        end
      end
      amdu_pkg::OP_LOAD_AX: ax = value;
      amdu_pkg::OP_LOAD_BX: bx = value;
      amdu_pkg::OP_LOAD_DX: dx = value;
      default: ;
    endcase
    ax_q = ax;
    bx_q = bx;
    dx_q = dx;
    cf_q = cf;
    res  = '{ax: ax, bx: bx, dx: dx, carry: cf, derr: derr};
    want_q.push_back(res);
  endtask

  always @(posedge clk) begin
    regs_rsp_t got, exp_r;
    if (rst) begin
      ax_q = '0;
      bx_q = '0;
      dx_q = '0;
      cf_q = 1'b0;
      want_q.delete();
    end else begin
      // result beat first: it belongs to an earlier operation
      if (rsp.valid && rsp.ready) begin
        got = '{ax: rsp.ax_out, bx: rsp.bx_out, dx: rsp.dx_out,
                carry: rsp.carry_out, derr: rsp.divide_error};
        if (want_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result beat with nothing outstanding: ax=%h bx=%h dx=%h c=%b de=%b",
                     $realtime, got.ax, got.bx, got.dx, got.carry, got.derr);
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch ax %h/%h bx %h/%h dx %h/%h carry %b/%b derr %b/%b (exp/got)",
                       $realtime, exp_r.ax, got.ax, exp_r.bx, got.bx, exp_r.dx, got.dx,
                       exp_r.carry, got.carry, exp_r.derr, got.derr);
          end
        end
      end
      if (req.valid && req.ready)
        exec_op(req.op, req.operand);
    end
    depth = want_q.size();
  end

endmodule

@@ bench/tb_accumulator_mul_div_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_mul_div_unit
// Drives operations into the multiply/divide unit: a directed run over the
// operand extremes, zero divisors, carry boundaries, swaps and unused codes,
// then random operations in segments with varying back-pressure on both
// channels and one long result stall. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_accumulator_mul_div_unit;

  typedef logic [amdu_pkg::OP_W-1:0] code_t;

  localparam code_t OP_UNUSED_FIRST = 4'd12;
  localparam code_t OP_UNUSED_LAST  = 4'd15;
  localparam int RAND_SEGS      = 9;
  localparam int SEG_ITEMS      = 200;
  localparam int HOLD_START     = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst;
  int   errors, pending;
  int   idle_pct = 20;
  int   quiet = 0;

  amdu_req_if req ();
  amdu_rsp_if rsp ();

  accumulator_mul_div_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  amdu_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  always #2 clk = ~clk;

  task automatic send_op(input code_t code, input amdu_pkg::word_t value);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.op      <= code;
    req.operand <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin
    code_t           code;
    amdu_pkg::word_t value;
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.op      <= '0;
    req.operand <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_op(amdu_pkg::OP_LOAD_AX, 16'hFFFF);
    send_op(amdu_pkg::OP_LOAD_BX, 16'h8000);
    send_op(amdu_pkg::OP_LOAD_DX, 16'h7FFF);
    send_op(amdu_pkg::OP_IMUL_BX, 16'hFFFF);    // -32768 * -1 fits unsigned: carry set
    send_op(amdu_pkg::OP_IMUL_DX, 16'h8000);    // negative product: carry clear
    send_op(amdu_pkg::OP_IMUL16, 16'h8000);
    send_op(amdu_pkg::OP_MUL16, 16'hFFFF);
    send_op(amdu_pkg::OP_DIV8, 16'h0001);       // quotient overflow, truncated
    send_op(amdu_pkg::OP_DIV8, 16'hFF00);       // zero low byte
    send_op(amdu_pkg::OP_DIV8, 16'h00FF);
    send_op(amdu_pkg::OP_LOAD_AX, 16'h0080);
    send_op(amdu_pkg::OP_IMUL8, 16'hFF80);
    send_op(amdu_pkg::OP_AAM, 16'h0000);
    send_op(amdu_pkg::OP_AAM, 16'h000A);
    send_op(amdu_pkg::OP_AAM, 16'h0100);        // divisor above AL
    send_op(amdu_pkg::OP_SWAP_AXDX, 16'h1234);
    send_op(amdu_pkg::OP_SWAP_BXAX, 16'hABCD);
    send_op(amdu_pkg::OP_LOAD_DX, 16'h00FF);
    send_op(amdu_pkg::OP_IMUL_DX, 16'h0101);    // product 0xFFFF: carry set
    send_op(amdu_pkg::OP_LOAD_DX, 16'h0100);
    send_op(amdu_pkg::OP_IMUL_DX, 16'h0100);    // product 0x10000: carry clear
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      send_op(code_t'(c), 16'h5A5A);

    for (int seg = 0; seg < RAND_SEGS; seg++) begin
      if (seg == RAND_SEGS - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if ($urandom_range(0, 19) == 0)
          code = code_t'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
          code = code_t'($urandom_range(amdu_pkg::OP_DIV8, amdu_pkg::OP_LOAD_DX));
        case ($urandom_range(0, 9))
          0: value = 16'h0000;
          1: value = 16'hFFFF;
          2: value = 16'h8000;
          3: value = 16'h7FFF;
          4: value = amdu_pkg::word_t'($urandom_range(0, 255));
          5: value = {8'($urandom_range(0, 255)), 8'h00};
          default: value = amdu_pkg::word_t'($urandom);
        endcase
        send_op(code, value);
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: short stalls, plus one long hold-off so the unit backs up
  initial begin
    int  loops;
    bit  held;
    loops = 0;
    held  = 1'b0;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      loops++;
      if (!held && loops == HOLD_START) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp.ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // no beat on either channel for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
